### hw/rtl/gregorian_date_step_unit_assert.svh
// assertion macros for the date step unit
`ifndef GREGORIAN_DATE_STEP_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_STEP_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GDSU_ASSERT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define GDSU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define GDSU_ASSERT(lbl, ck, rs, ante, cons, msg)
`define GDSU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

### hw/rtl/gdsu_pkg.sv
// types, constants and calendar tables for the date step unit
`default_nettype none

package gdsu_pkg;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int FUNC_W = 3;
  localparam int WD_W   = 3;
  localparam int DOY_W  = 9;
  localparam int ORD_W  = 2;
  localparam int MASK_W = 7;
  localparam int SUM_W  = 15;

  localparam int YEAR_LIMIT_DEFAULT = 9999;
  localparam logic [MASK_W-1:0] WEEKEND_MASK_RESET = 7'd96;

  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [MON_W-1:0]  month_t;
  typedef logic [DAY_W-1:0]  day_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [WD_W-1:0]   weekday_t;
  typedef logic [DOY_W-1:0]  doy_t;
  typedef logic [ORD_W-1:0]  order_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam func_t FN_LOAD       = 3'd0;
  localparam func_t FN_NEXT_DAY   = 3'd1;
  localparam func_t FN_PREV_DAY   = 3'd2;
  localparam func_t FN_NEXT_MONTH = 3'd3;
  localparam func_t FN_PREV_MONTH = 3'd4;
  localparam func_t FN_COMPARE    = 3'd5;

  localparam order_t ORD_BEFORE = 2'd0;
  localparam order_t ORD_EQUAL  = 2'd1;
  localparam order_t ORD_AFTER  = 2'd2;

  localparam month_t MON_JAN = 4'd1;
  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_DEC = 4'd12;

  localparam logic [5:0] DIV_CENTURY = 6'd25;
  localparam logic [5:0] DIV_WEEK    = 6'd7;

  function automatic day_t days_in_month(input month_t m, input logic lp);
    day_t len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        4'd2:                                       len = lp ? 5'd29 : 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

  function automatic doy_t month_start(input month_t m);
    doy_t s;
    begin
      case (m)
        4'd1:    s = 9'd0;
        4'd2:    s = 9'd31;
        4'd3:    s = 9'd59;
        4'd4:    s = 9'd90;
        4'd5:    s = 9'd120;
        4'd6:    s = 9'd151;
        4'd7:    s = 9'd181;
        4'd8:    s = 9'd212;
        4'd9:    s = 9'd243;
        4'd10:   s = 9'd273;
        4'd11:   s = 9'd304;
        4'd12:   s = 9'd334;
        default: s = 9'd0;
      endcase
      return s;
    end
  endfunction

  // month term of the weekday sum, march-based month numbering folded in
  function automatic logic [4:0] wd_month_off(input month_t m);
    logic [4:0] o;
    begin
      case (m)
        4'd1:    o = 5'd28;
        4'd2:    o = 5'd31;
        4'd3:    o = 5'd2;
        4'd4:    o = 5'd5;
        4'd5:    o = 5'd7;
        4'd6:    o = 5'd10;
        4'd7:    o = 5'd12;
        4'd8:    o = 5'd15;
        4'd9:    o = 5'd18;
        4'd10:   o = 5'd20;
        4'd11:   o = 5'd23;
        4'd12:   o = 5'd25;
        default: o = 5'd0;
      endcase
      return o;
    end
  endfunction

  // leap test from the year and (year / 4) mod 25
  function automatic logic leap_of(input year_t y, input logic [4:0] r25);
    return (y[1:0] == 2'd0) && ((r25 != 5'd0) || (y[3:2] == 2'd0));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gregorian_date_step_unit.sv
// date step unit: stored date, command sequencer and shared reciprocal divider
// each accepted word takes four divide passes on the one shared multiplier, each pass a
// reciprocal multiply, then the remainder, then use of it; an output state then writes the
// result word, and no new word is taken before that result word is written
// the input is stalled while a word is in work; a held result only delays the last step
// synchronous reset: date 1 january of year 1, weekend mask 96, no result pending
`default_nettype none

`include "gregorian_date_step_unit_assert.svh"

module gregorian_date_step_unit #(
  parameter int YEAR_LIMIT = gdsu_pkg::YEAR_LIMIT_DEFAULT
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_wr_en,
  input  wire  gdsu_pkg::mask_t cfg_wr_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  gdsu_pkg::func_t func,
  input  wire  gdsu_pkg::year_t in_year,
  input  wire  gdsu_pkg::month_t in_month,
  input  wire  gdsu_pkg::day_t  in_day,
  output logic                  out_valid,
  input  wire                   out_stall,
  output gdsu_pkg::year_t       out_year,
  output gdsu_pkg::month_t      out_month,
  output gdsu_pkg::day_t        out_day,
  output gdsu_pkg::weekday_t    weekday,
  output gdsu_pkg::doy_t        day_of_year,
  output logic                  is_weekend,
  output gdsu_pkg::day_t        days_to_month_end,
  output gdsu_pkg::doy_t        days_to_year_end,
  output gdsu_pkg::order_t      order,
  output logic                  range_error
);
  import gdsu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [1:0] P_LEAP0 = 2'd0;
  localparam logic [1:0] P_LEAP1 = 2'd1;
  localparam logic [1:0] P_WDIV  = 2'd2;
  localparam logic [1:0] P_MOD7  = 2'd3;

  localparam int PROD_W = SUM_W + 16;

  // ceil(2^16 / 25) and ceil(2^18 / 7), exact over the dividend ranges used
  localparam logic [15:0] RECIP_CENTURY = 16'd2622;
  localparam logic [15:0] RECIP_WEEK    = 16'd37450;

  localparam year_t YL = YEAR_W'(YEAR_LIMIT);

  logic [1:0]       state;
  logic [1:0]       pass;
  logic             cnt;
  logic [SUM_W-1:0] dq;
  logic [12:0]      quo;
  logic [4:0]       rem;
  logic [SUM_W-1:0] s0;

  year_t    cur_year;
  month_t   cur_month;
  day_t     cur_day;
  mask_t    weekend_mask;
  func_t    op;
  year_t    iy;
  month_t   im;
  day_t     id;
  logic     err;
  logic     leap1;
  weekday_t wd;

  // shared reciprocal multiply, remainder from the registered quotient
  logic [5:0]        divisor;
  logic [15:0]       recip;
  logic [PROD_W-1:0] prod;
  logic [12:0]       quo_now;
  logic [SUM_W-1:0]  rem_now;

  assign divisor = (pass == P_MOD7) ? DIV_WEEK : DIV_CENTURY;
  assign recip   = (pass == P_MOD7) ? RECIP_WEEK : RECIP_CENTURY;
  assign prod    = PROD_W'(dq) * PROD_W'(recip);
  assign quo_now = (pass == P_MOD7) ? prod[PROD_W-1:18] : {1'b0, prod[27:16]};
  assign rem_now = dq - SUM_W'(quo) * SUM_W'(divisor);

  // leap of the year just divided
  year_t ysel;
  logic  leap_now;

  assign ysel     = ((pass == P_LEAP0) && (op == FN_LOAD)) ? iy : cur_year;
  assign leap_now = leap_of(ysel, rem);

  // command applied to the stored date
  year_t  cy_n;
  month_t cm_n;
  day_t   cd_n;
  logic   err_n;
  day_t   len_cur;
  day_t   len_new;

  always_comb begin
    cy_n    = cur_year;
    cm_n    = cur_month;
    cd_n    = cur_day;
    err_n   = 1'b0;
    len_cur = days_in_month(cur_month, leap_now);
    len_new = 5'd0;
    unique case (op)
      FN_LOAD: begin
        if ((iy != '0) && (iy <= YL) && (im >= MON_JAN) && (im <= MON_DEC) &&
            (id != '0) && (id <= days_in_month(im, leap_now))) begin
          cy_n = iy;
          cm_n = im;
          cd_n = id;
        end else begin
          err_n = 1'b1;
        end
      end
      FN_NEXT_DAY: begin
        priority if (cur_day < len_cur) begin
          cd_n = cur_day + 5'd1;
        end else if (cur_month < MON_DEC) begin
          cm_n = cur_month + 4'd1;
          cd_n = 5'd1;
        end else if (cur_year < YL) begin
          cy_n = cur_year + 14'd1;
          cm_n = MON_JAN;
          cd_n = 5'd1;
        end else begin
          err_n = 1'b1;
        end
      end
      FN_PREV_DAY: begin
        priority if (cur_day > 5'd1) begin
          cd_n = cur_day - 5'd1;
        end else if (cur_month > MON_JAN) begin
          cm_n = cur_month - 4'd1;
          cd_n = days_in_month(cur_month - 4'd1, leap_now);
        end else if (cur_year > 14'd1) begin
          cy_n = cur_year - 14'd1;
          cm_n = MON_DEC;
          cd_n = 5'd31;
        end else begin
          err_n = 1'b1;
        end
      end
      FN_NEXT_MONTH, FN_PREV_MONTH: begin
        priority if ((op == FN_NEXT_MONTH) && (cur_month == MON_DEC) && (cur_year >= YL)) begin
          err_n = 1'b1;
        end else if ((op == FN_PREV_MONTH) && (cur_month == MON_JAN) &&
                     (cur_year <= 14'd1)) begin
          err_n = 1'b1;
        end else begin
          if (op == FN_NEXT_MONTH) begin
            if (cur_month == MON_DEC) begin
              cy_n = cur_year + 14'd1;
              cm_n = MON_JAN;
            end else begin
              cm_n = cur_month + 4'd1;
            end
          end else begin
            if (cur_month == MON_JAN) begin
              cy_n = cur_year - 14'd1;
              cm_n = MON_DEC;
            end else begin
              cm_n = cur_month - 4'd1;
            end
          end
          // a year crossing lands on january or december, so the old leap bit serves
          len_new = days_in_month(cm_n, leap_now);
          if (cur_day > len_new) begin
            cd_n = len_new;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // weekday sum parts
  logic             march_base;
  year_t            yy;
  logic [SUM_W-1:0] s0_n;
  logic [11:0]      q100;
  logic [SUM_W-1:0] wsum;
  year_t            accept_year;

  assign march_base  = (cur_month <= MON_FEB);
  assign yy          = cur_year - YEAR_W'(march_base);
  assign s0_n        = SUM_W'(cur_day) + SUM_W'(yy) + SUM_W'(yy[13:2]) +
                       SUM_W'(wd_month_off(cur_month));
  assign q100        = quo[11:0];
  assign wsum        = s0 - SUM_W'(q100) + SUM_W'(q100[11:2]);
  assign accept_year = (func == FN_LOAD) ? in_year : cur_year;

  // result fields of the stored date
  day_t   len_out;
  doy_t   doy;
  doy_t   ylen;
  order_t ord;

  always_comb begin
    len_out = days_in_month(cur_month, leap1);
    doy     = DOY_W'(cur_day) + month_start(cur_month) +
              DOY_W'((cur_month > MON_FEB) && leap1);
    ylen    = leap1 ? 9'd366 : 9'd365;
    priority if (cur_year != iy) begin
      ord = (cur_year < iy) ? ORD_BEFORE : ORD_AFTER;
    end else if (cur_month != im) begin
      ord = (cur_month < im) ? ORD_BEFORE : ORD_AFTER;
    end else if (cur_day != id) begin
      ord = (cur_day < id) ? ORD_BEFORE : ORD_AFTER;
    end else begin
      ord = ORD_EQUAL;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pass         <= P_LEAP0;
      cnt          <= 1'b0;
      cur_year     <= 14'd1;
      cur_month    <= MON_JAN;
      cur_day      <= 5'd1;
      weekend_mask <= WEEKEND_MASK_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        weekend_mask <= cfg_wr_data;
      end
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= func;
            iy    <= in_year;
            im    <= in_month;
            id    <= in_day;
            pass  <= P_LEAP0;
            dq    <= SUM_W'(accept_year[13:2]);
            rem   <= '0;
            cnt   <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt) begin
            quo <= quo_now;
            cnt <= 1'b0;
          end else begin
            rem   <= rem_now[4:0];
            state <= S_POST;
          end
        end
        S_POST: begin
          rem <= '0;
          unique case (pass)
            P_LEAP0: begin
              cur_year  <= cy_n;
              cur_month <= cm_n;
              cur_day   <= cd_n;
              err       <= err_n;
              dq        <= SUM_W'(cy_n[13:2]);
              cnt       <= 1'b1;
              pass      <= P_LEAP1;
              state     <= S_DIV;
            end
            P_LEAP1: begin
              leap1 <= leap_now;
              s0    <= s0_n;
              dq    <= SUM_W'(yy[13:2]);
              cnt   <= 1'b1;
              pass  <= P_WDIV;
              state <= S_DIV;
            end
            P_WDIV: begin
              dq    <= wsum;
              cnt   <= 1'b1;
              pass  <= P_MOD7;
              state <= S_DIV;
            end
            P_MOD7: begin
              wd    <= rem[WD_W-1:0];
              state <= S_FIN;
            end
            default: begin
            end
          endcase
        end
        S_FIN: begin
          if (!(out_valid && out_stall)) begin
            out_year          <= cur_year;
            out_month         <= cur_month;
            out_day           <= cur_day;
            weekday           <= wd;
            day_of_year       <= doy;
            is_weekend        <= weekend_mask[wd];
            days_to_month_end <= len_out - cur_day;
            days_to_year_end  <= ylen - doy;
            order             <= ord;
            range_error       <= err;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GDSU_ASSERT(a_date_valid, clk, rst, 1'b1, (cur_year != '0) && (cur_month >= MON_JAN) && (cur_month <= MON_DEC) && (cur_day != '0), "stored date left the calendar")
  `GDSU_ASSERT(a_rem_bound, clk, rst, state == S_POST, rem < divisor[4:0], "divider remainder not below divisor")
  `GDSU_ASSERT_NEXT(a_accept_start, clk, rst, in_valid && !in_stall, (state == S_DIV) && (pass == P_LEAP0), "accepted word did not start the first pass")

endmodule

`default_nettype wire

### tb/sv/date_step_checker.sv
// checker for the date step unit: predicts every result word and compares it field by field
`timescale 1ns / 1ps

module date_step_checker #(
  parameter int YEAR_MAX = gdsu_pkg::YEAR_LIMIT_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_wr_en,
  input  gdsu_pkg::mask_t    cfg_wr_data,
  input  wire                in_valid,
  input  wire                in_stall,
  input  gdsu_pkg::func_t    func,
  input  gdsu_pkg::year_t    in_year,
  input  gdsu_pkg::month_t   in_month,
  input  gdsu_pkg::day_t     in_day,
  input  wire                out_valid,
  input  wire                out_stall,
  input  gdsu_pkg::year_t    out_year,
  input  gdsu_pkg::month_t   out_month,
  input  gdsu_pkg::day_t     out_day,
  input  gdsu_pkg::weekday_t weekday,
  input  gdsu_pkg::doy_t     day_of_year,
  input  wire                is_weekend,
  input  gdsu_pkg::day_t     days_to_month_end,
  input  gdsu_pkg::doy_t     days_to_year_end,
  input  gdsu_pkg::order_t   order,
  input  wire                range_error,
  output int                 n_waiting,
  output int                 n_fail
);
  import gdsu_pkg::*;

  typedef struct packed {
    year_t    year;
    month_t   month;
    day_t     day;
    weekday_t wd;
    doy_t     doy;
    logic     weekend;
    day_t     to_month_end;
    doy_t     to_year_end;
    order_t   ord;
    logic     refused;
  } date_result_t;

  date_result_t expected_dates[$];
  mask_t        weekend_days;
  int unsigned  date_year;
  int unsigned  date_month;
  int unsigned  date_day;

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // march-based year so that the leap day falls at the end
  function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
    int unsigned early;
    int unsigned yy;
    int unsigned mm;
    early = (m <= 2) ? 1 : 0;
    yy = y - early;
    mm = m + 12 * early - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  function automatic date_result_t apply_command(func_t f, year_t iy, month_t im, day_t id);
    date_result_t r;
    int unsigned  len;
    int unsigned  doy;
    int unsigned  wd;
    int unsigned  y_in;
    int unsigned  m_in;
    int unsigned  d_in;
    logic [22:0]  here;
    logic [22:0]  there;
    logic         refused;
    refused = 1'b0;
    y_in = 32'(iy);
    m_in = 32'(im);
    d_in = 32'(id);
    case (f)
      FN_LOAD: begin
        if (y_in >= 1 && y_in <= YEAR_MAX && m_in >= 1 && m_in <= 12 && d_in >= 1 &&
            d_in <= month_days(y_in, m_in)) begin
          date_year = y_in;
          date_month = m_in;
          date_day = d_in;
        end else begin
          refused = 1'b1;
        end
      end
      FN_NEXT_DAY: begin
        if (date_day < month_days(date_year, date_month)) begin
          date_day++;
        end else if (date_month < 12) begin
          date_month++;
          date_day = 1;
        end else if (date_year < YEAR_MAX) begin
          date_year++;
          date_month = 1;
          date_day = 1;
        end else begin
          refused = 1'b1;
        end
      end
      FN_PREV_DAY: begin
        if (date_day > 1) begin
          date_day--;
        end else if (date_month > 1) begin
          date_month--;
          date_day = month_days(date_year, date_month);
        end else if (date_year > 1) begin
          date_year--;
          date_month = 12;
          date_day = 31;
        end else begin
          refused = 1'b1;
        end
      end
      FN_NEXT_MONTH: begin
        if (date_month == 12 && date_year >= YEAR_MAX) begin
          refused = 1'b1;
        end else begin
          if (date_month == 12) begin
            date_year++;
            date_month = 1;
          end else begin
            date_month++;
          end
          if (date_day > month_days(date_year, date_month))
            date_day = month_days(date_year, date_month);
        end
      end
      FN_PREV_MONTH: begin
        if (date_month == 1 && date_year <= 1) begin
          refused = 1'b1;
        end else begin
          if (date_month == 1) begin
            date_year--;
            date_month = 12;
          end else begin
            date_month--;
          end
          if (date_day > month_days(date_year, date_month))
            date_day = month_days(date_year, date_month);
        end
      end
      default: begin
      end
    endcase

    len = month_days(date_year, date_month);
    wd = day_of_week(date_year, date_month, date_day);
    doy = date_day;
    for (int k = 1; k < date_month; k++)
      doy += month_days(date_year, k);

    here = {year_t'(date_year), month_t'(date_month), day_t'(date_day)};
    there = {iy, im, id};

    r.year = year_t'(date_year);
    r.month = month_t'(date_month);
    r.day = day_t'(date_day);
    r.wd = weekday_t'(wd);
    r.doy = doy_t'(doy);
    r.weekend = weekend_days[wd];
    r.to_month_end = day_t'(len - date_day);
    r.to_year_end = doy_t'((is_leap(date_year) ? 366 : 365) - doy);
    r.ord = (here == there) ? ORD_EQUAL : ((here < there) ? ORD_BEFORE : ORD_AFTER);
    r.refused = refused;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t want;
    if (rst) begin
      weekend_days = WEEKEND_MASK_RESET;
      date_year = 1;
      date_month = 1;
      date_day = 1;
      expected_dates.delete();
      n_fail = 0;
    end else begin
      if (cfg_wr_en)
        weekend_days = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          $error("result word with nothing expected");
          n_fail++;
        end else begin
          want = expected_dates.pop_front();
          check_field("out_year", 32'(want.year), 32'(out_year));
          check_field("out_month", 32'(want.month), 32'(out_month));
          check_field("out_day", 32'(want.day), 32'(out_day));
          check_field("weekday", 32'(want.wd), 32'(weekday));
          check_field("day_of_year", 32'(want.doy), 32'(day_of_year));
          check_field("is_weekend", 32'(want.weekend), 32'(is_weekend));
          check_field("days_to_month_end", 32'(want.to_month_end), 32'(days_to_month_end));
          check_field("days_to_year_end", 32'(want.to_year_end), 32'(days_to_year_end));
          check_field("order", 32'(want.ord), 32'(order));
          check_field("range_error", 32'(want.refused), 32'(range_error));
        end
      end
      if (in_valid && !in_stall)
        expected_dates.push_back(apply_command(func, in_year, in_month, in_day));
    end
    n_waiting <= expected_dates.size();
  end

endmodule

### tb/sv/tb.sv
// top of the date step unit testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import gdsu_pkg::*;

  localparam func_t FN_SPARE_LO = 3'd6;
  localparam func_t FN_SPARE_HI = 3'd7;
  localparam int    IDLE_LIMIT  = 4000;
  localparam int    PHASE_WORDS = 200;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_wr_en;
  mask_t    cfg_wr_data;
  logic     in_valid;
  logic     in_stall;
  func_t    func;
  year_t    in_year;
  month_t   in_month;
  day_t     in_day;
  logic     out_valid;
  logic     out_stall = 1'b0;
  year_t    out_year;
  month_t   out_month;
  day_t     out_day;
  weekday_t weekday;
  doy_t     day_of_year;
  logic     is_weekend;
  day_t     days_to_month_end;
  doy_t     days_to_year_end;
  order_t   order;
  logic     range_error;
  int       n_waiting;
  int       n_fail;

  int       burst_left = 0;
  int       stall_mode = 0;
  int       stall_span = 0;
  int       idle_cycles = 0;
  year_t    last_year = 1;
  month_t   last_month = 1;
  day_t     last_day = 1;
  mask_t    mask_plan[6];

  gregorian_date_step_unit u_top (.*);

  date_step_checker u_checker (.*);

  always #4 clk = ~clk;

  // receiver stall pattern: free, light, heavy or long runs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(50, 400);
      end
      stall_span--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0)
            out_stall <= ~out_stall;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_command(func_t f, year_t y, month_t m, day_t d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(0, 12);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    func <= f;
    in_year <= y;
    in_month <= m;
    in_day <= d;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (f == FN_LOAD) begin
      last_year = y;
      last_month = m;
      last_day = d;
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
  endtask

  task automatic write_weekend_mask(mask_t m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic year_t pick_year();
    year_t y;
    case ($urandom_range(0, 5))
      0:       y = year_t'($urandom_range(1, 4));
      1:       y = year_t'($urandom_range(YEAR_LIMIT_DEFAULT - 3, YEAR_LIMIT_DEFAULT));
      2:       y = year_t'($urandom_range(1896, 1904));
      3:       y = year_t'($urandom_range(1996, 2004));
      4:       y = year_t'($urandom_range(2096, 2104));
      default: y = year_t'($urandom_range(1, YEAR_LIMIT_DEFAULT));
    endcase
    return y;
  endfunction

  function automatic day_t pick_day();
    return day_t'(($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) :
                  $urandom_range(1, 28));
  endfunction

  task automatic random_commands(int count);
    int    sent;
    int    r;
    int    run;
    func_t f;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      f = func_t'($urandom_range(FN_NEXT_DAY, FN_PREV_MONTH));
      if (r < 10) begin
        run = $urandom_range(5, 30);
        repeat (run) send_command(f, last_year, last_month, last_day);
        sent += run;
      end else if (r < 30) begin
        send_command(FN_LOAD, pick_year(), month_t'($urandom_range(1, 12)), pick_day());
        sent++;
      end else if (r < 65) begin
        if ($urandom_range(0, 1) == 0)
          send_command(f, last_year, last_month, last_day);
        else
          send_command(f, pick_year(), month_t'($urandom_range(1, 12)), pick_day());
        sent++;
      end else if (r < 80) begin
        send_command(FN_COMPARE, last_year, last_month, last_day);
        sent++;
      end else if (r < 98) begin
        send_command(func_t'($urandom_range(0, 7)), year_t'($urandom_range(0, 16383)),
                     month_t'($urandom_range(0, 15)), day_t'($urandom_range(0, 31)));
        sent++;
      end else begin
        wait_for_results();
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    func <= FN_COMPARE;
    in_year <= '0;
    in_month <= '0;
    in_day <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_command(FN_COMPARE, 1, 1, 1);
    send_command(FN_PREV_DAY, 1, 1, 1);
    send_command(FN_PREV_MONTH, 1, 1, 1);
    send_command(FN_SPARE_HI, 16383, 15, 31);
    send_command(FN_SPARE_LO, 0, 0, 0);
    send_command(FN_LOAD, 0, 1, 1);
    send_command(FN_LOAD, 16383, 15, 31);
    send_command(FN_LOAD, 2023, 13, 1);
    send_command(FN_LOAD, 2023, 4, 31);
    send_command(FN_LOAD, 1900, 2, 29);
    send_command(FN_LOAD, 2023, 5, 0);
    send_command(FN_LOAD, 2000, 1, 31);
    send_command(FN_NEXT_MONTH, 2000, 2, 29);
    send_command(FN_NEXT_DAY, 2000, 3, 1);
    send_command(FN_PREV_DAY, 2000, 3, 1);
    send_command(FN_LOAD, 1900, 3, 31);
    send_command(FN_PREV_MONTH, 1900, 2, 28);
    send_command(FN_LOAD, 9999, 12, 31);
    send_command(FN_NEXT_DAY, 9999, 12, 31);
    send_command(FN_NEXT_MONTH, 1, 1, 1);
    send_command(FN_PREV_MONTH, 9999, 12, 31);
    send_command(FN_LOAD, 1999, 12, 31);
    send_command(FN_NEXT_DAY, 2000, 1, 1);
    send_command(FN_LOAD, 2004, 12, 31);
    send_command(FN_NEXT_MONTH, 2005, 1, 31);

    mask_plan = '{7'h7F, 7'h00, 7'h01, 7'h40, mask_t'($urandom), mask_t'($urandom)};
    foreach (mask_plan[i]) begin
      wait_for_results();
      write_weekend_mask(mask_plan[i]);
      random_commands(PHASE_WORDS);
    end

    wait_for_results();
    repeat (60) @(posedge clk);
    if (n_fail == 0 && n_waiting == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gdsu_pkg.sv
hw/rtl/gregorian_date_step_unit.sv
tb/sv/date_step_checker.sv
tb/sv/tb.sv
